@@ design/maf_pkg.sv @@
`timescale 1ns / 1ps

package maf_pkg;

    // Ring size and field widths.
    localparam int DEPTH       = 1024;
    localparam int SAMPLE_BITS = 12;
    localparam int IDX_BITS    = 10;
    localparam int LEN_BITS    = 11;
    localparam int SUM_BITS    = 22;
    localparam int REM_BITS    = 11;
    localparam int CNT_BITS    = 4;
    localparam int QUEUE_DEPTH = 2;

    // Window length after reset, and the index of its oldest entry.
    localparam logic [LEN_BITS-1:0] RESET_LEN = LEN_BITS'(16);
    localparam logic [IDX_BITS-1:0] RESET_IDX = IDX_BITS'(15);
    localparam logic [LEN_BITS-1:0] MAX_LEN   = LEN_BITS'(DEPTH);

    // Number of quotient bits the divider produces.
    localparam logic [CNT_BITS-1:0] QUOT_STEPS = CNT_BITS'(SAMPLE_BITS);

    // One classified beat waiting in the queue.
    typedef struct packed {
        logic                   prime;
        logic [SAMPLE_BITS-1:0] sample;
    } item_t;

    // Divider request and response.
    typedef struct packed {
        logic                start;
        logic [SUM_BITS-1:0] dividend;
        logic [LEN_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic [SAMPLE_BITS-1:0] quotient;
    } div_rsp_t;

    // Window length held between one and the ring size.
    function automatic logic [LEN_BITS-1:0] clamp_len(input logic [LEN_BITS-1:0] len);
        logic [LEN_BITS-1:0] res;
        res = len;
        if (len == '0)
        begin
            res = LEN_BITS'(1);
        end
        else if (len > MAX_LEN)
        begin
            res = MAX_LEN;
        end
        return res;
    endfunction

endpackage

@@ design/maf_front.sv @@
`timescale 1ns / 1ps

module maf_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,
    input  logic [0:0]                          s_axis_tuser,
    input  logic                                q_pop,
    output logic                                q_valid,
    output maf_pkg::item_t                      q_item
);

    maf_pkg::item_t queue_mem [maf_pkg::QUEUE_DEPTH];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           push;
    logic           pop;
    maf_pkg::item_t in_item;

    // Classify the incoming beat: the user bit marks a prime.
    always_comb
    begin
        in_item.prime  = s_axis_tuser[0];
        in_item.sample = s_axis_tdata[maf_pkg::SAMPLE_BITS-1:0];
    end

    assign s_axis_tready = (count_reg != 2'(maf_pkg::QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != 2'd0);
    assign pop           = q_pop && q_valid;
    assign q_item        = queue_mem[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= in_item;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ design/maf_div.sv @@
`timescale 1ns / 1ps

module maf_div (
    input  logic              clk,
    input  logic              rst_n,
    input  maf_pkg::div_req_t req,
    output maf_pkg::div_rsp_t rsp
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [maf_pkg::CNT_BITS-1:0]       cnt_reg;
    logic [maf_pkg::REM_BITS-1:0]       rem_reg;
    logic [maf_pkg::SAMPLE_BITS-1:0]    dvd_reg;
    logic [maf_pkg::LEN_BITS-1:0]       dsr_reg;
    logic [maf_pkg::REM_BITS:0]         trial;
    logic                               ge;
    logic [maf_pkg::REM_BITS-1:0]       rem_next;
    logic [maf_pkg::REM_BITS:0]         diff;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[maf_pkg::SAMPLE_BITS-1]};
        ge       = (trial >= {1'b0, dsr_reg});
        diff     = trial - {1'b0, dsr_reg};
        rem_next = ge ? diff[maf_pkg::REM_BITS-1:0] : trial[maf_pkg::REM_BITS-1:0];
    end

    // The upper dividend bits are already below the divisor, so they seed the
    // remainder and only the low bits need steps.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= {1'b0, req.dividend[maf_pkg::SUM_BITS-1:maf_pkg::SAMPLE_BITS]};
            dvd_reg <= req.dividend[maf_pkg::SAMPLE_BITS-1:0];
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[maf_pkg::SAMPLE_BITS-2:0], ge};
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == maf_pkg::QUOT_STEPS - 1'b1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

@@ design/maf_back.sv @@
`timescale 1ns / 1ps

module maf_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [maf_pkg::LEN_BITS-1:0]       cfg_wr_data,
    input  logic                               q_valid,
    input  maf_pkg::item_t                     q_item,
    output logic                               q_pop,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [15:0]                        m_axis_tdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PRIME  = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]                         state_reg;
    logic [2:0]                         state_next;
    logic [maf_pkg::LEN_BITS-1:0]       wlen_reg;
    logic [maf_pkg::LEN_BITS-1:0]       len_reg;
    logic [maf_pkg::IDX_BITS-1:0]       idx_reg;
    logic [maf_pkg::SUM_BITS-1:0]       sum_reg;
    logic [maf_pkg::SUM_BITS-1:0]       sum_next;
    logic [maf_pkg::LEN_BITS-1:0]       fill_cnt_reg;
    logic [maf_pkg::SAMPLE_BITS-1:0]    prime_val_reg;
    logic [maf_pkg::SAMPLE_BITS-1:0]    cur_reg;
    logic [maf_pkg::SAMPLE_BITS-1:0]    res_reg;
    logic [maf_pkg::SAMPLE_BITS-1:0]    rd_data_reg;
    logic [maf_pkg::SAMPLE_BITS-1:0]    oldest;
    logic [maf_pkg::SAMPLE_BITS-1:0]    ring_mem [maf_pkg::DEPTH];
    logic [maf_pkg::LEN_BITS-1:0]       clamped;
    logic [maf_pkg::LEN_BITS+maf_pkg::SAMPLE_BITS-1:0] prime_prod;
    logic                               out_valid_reg;
    logic [maf_pkg::SAMPLE_BITS-1:0]    out_data_reg;
    logic                               out_free;
    maf_pkg::div_req_t                  div_req;
    maf_pkg::div_rsp_t                  div_rsp;

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign clamped  = maf_pkg::clamp_len(wlen_reg);

    // Entries not yet overwritten since the last prime still hold its value.
    assign oldest     = (fill_cnt_reg < len_reg) ? prime_val_reg : rd_data_reg;
    assign sum_next   = sum_reg + maf_pkg::SUM_BITS'(cur_reg) - maf_pkg::SUM_BITS'(oldest);
    assign prime_prod = len_reg * prime_val_reg;

    // Divider request issued as the sum is updated.
    always_comb
    begin
        div_req.start    = (state_reg == S_UPDATE);
        div_req.dividend = sum_next;
        div_req.divisor  = len_reg;
    end

    maf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sample ring with a registered read port at the oldest index.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_UPDATE)
        begin
            ring_mem[idx_reg] <= cur_reg;
        end
        rd_data_reg <= ring_mem[idx_reg];
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_item.prime ? S_PRIME : S_READ;
                end
            end
            S_PRIME:  state_next = S_DONE;
            S_READ:   state_next = S_UPDATE;
            S_UPDATE: state_next = S_DIV;
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Payload held for the item in progress.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_item.sample;
        end
        if (state_reg == S_PRIME)
        begin
            res_reg <= prime_val_reg;
        end
        else if (state_reg == S_DIV && div_rsp.done)
        begin
            res_reg <= div_rsp.quotient;
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_data_reg <= res_reg;
        end
    end

    // Filter state; reset looks like a prime with value zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wlen_reg      <= maf_pkg::RESET_LEN;
            len_reg       <= maf_pkg::RESET_LEN;
            idx_reg       <= maf_pkg::RESET_IDX;
            sum_reg       <= '0;
            fill_cnt_reg  <= '0;
            prime_val_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                wlen_reg <= cfg_wr_data;
            end
            if (q_pop && q_item.prime)
            begin
                len_reg       <= clamped;
                idx_reg       <= maf_pkg::IDX_BITS'(clamped - 1'b1);
                fill_cnt_reg  <= '0;
                prime_val_reg <= q_item.sample;
            end
            if (state_reg == S_PRIME)
            begin
                sum_reg <= prime_prod[maf_pkg::SUM_BITS-1:0];
            end
            if (state_reg == S_UPDATE)
            begin
                sum_reg <= sum_next;
                if (idx_reg == '0)
                begin
                    idx_reg <= maf_pkg::IDX_BITS'(len_reg - 1'b1);
                end
                else
                begin
                    idx_reg <= idx_reg - 1'b1;
                end
                if (fill_cnt_reg < len_reg)
                begin
                    fill_cnt_reg <= fill_cnt_reg + 1'b1;
                end
            end
            // Output register.
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_data_reg};

endmodule

@@ design/moving_average_filter.sv @@
`timescale 1ns / 1ps

// Boxcar moving average of 12-bit samples over a window of 1 to 1024 entries.
// Input beats arrive on the s_axis group: tdata carries the sample, tuser[0]
// says whether the beat filters a new sample (0) or primes the window with it (1).
// Each input beat yields exactly one output beat on the m_axis group, whose
// tdata carries the truncated average.
// cfg_wr_en/cfg_wr_data write the window length; it takes effect at the next
// prime, and 0 counts as 1 while values above 1024 count as 1024.
// A two-beat queue decouples the input from the processing, so input beats are
// taken while a result waits on the output.
// A filter beat passes through the queue, the ring read, the sum update and a
// 12-step serial divider; each item is finished before the next leaves the queue.
// A prime beat skips the ring read and the divider and returns the prime value.
// After reset the window is 16 entries of zero with a zero sum, as if primed
// with zero; no clearing pass is needed. If the receiver stalls, the result
// stays in the output register, one further item is processed and held, and
// then the queue fills and s_axis_tready drops.
module moving_average_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] sample, [15:12] zero
    input  logic [0:0]  s_axis_tuser,   // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [11:0] average, [15:12] zero
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data
);

    logic           q_valid;
    logic           q_pop;
    maf_pkg::item_t q_item;

    maf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_pop         (q_pop),
        .q_valid       (q_valid),
        .q_item        (q_item)
    );

    maf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
